/* src/drt_pkg.sv */
// Package for the dirty rectangle tracker: field widths, rectangle type,
// action and register codes, and the containment test.
// No dependencies.
package drt_pkg;

    localparam int COORD_W = 11;
    localparam int EDGE_W = 12;
    localparam int SCALE_W = 3;
    localparam int OFFSET_W = 8;
    localparam int POS_X_W = 9;
    localparam int POS_Y_W = 8;
    localparam int GROUPS_W = 7;
    localparam int ROWS_W = 8;
    localparam int ACTION_W = 3;
    localparam int OUT_IDX_W = 4;
    localparam int OUT_CNT_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_DROP    = 3'd0,
        ACT_REPLACE = 3'd1,
        ACT_APPEND  = 3'd2,
        ACT_FULL    = 3'd3,
        ACT_FLUSH   = 3'd4
    } action_t;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_H_SCALE = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } rect_t;

    // control that travels down the cell chain with the probe rectangle
    typedef struct packed {
        logic    valid;
        logic    done;
        action_t action;
    } probe_ctrl_t;

    // a lies inside b; edges formed at 12 bits so they never wrap
    function automatic logic rect_inside(rect_t a, rect_t b);
        logic [EDGE_W-1:0] ar;
        logic [EDGE_W-1:0] ab;
        logic [EDGE_W-1:0] br;
        logic [EDGE_W-1:0] bb;
        ar = EDGE_W'(a.x) + EDGE_W'(a.w);
        ab = EDGE_W'(a.y) + EDGE_W'(a.h);
        br = EDGE_W'(b.x) + EDGE_W'(b.w);
        bb = EDGE_W'(b.y) + EDGE_W'(b.h);
        return (a.x >= b.x) && (a.y >= b.y) && (ar <= br) && (ab <= bb);
    endfunction

endpackage

/* src/drt_if.sv */
// Channel interfaces of the dirty rectangle tracker: request, result and
// configuration write. Depends on drt_pkg.
interface drt_req_if import drt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [POS_X_W-1:0]  pos_x;
    logic [POS_Y_W-1:0]  pos_y;
    logic [GROUPS_W-1:0] width_groups;
    logic [ROWS_W-1:0]   height_rows;

    modport source (output valid, req_type, pos_x, pos_y, width_groups, height_rows,
                    input ready);
    modport sink (input valid, req_type, pos_x, pos_y, width_groups, height_rows,
                  output ready);
endinterface

interface drt_res_if import drt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [OUT_IDX_W-1:0] entry_index;
    logic [OUT_CNT_W-1:0] pending_count;
    logic [COORD_W-1:0]   scr_x;
    logic [COORD_W-1:0]   scr_y;
    logic [COORD_W-1:0]   scr_w;
    logic [COORD_W-1:0]   scr_h;

    modport source (output valid, action, entry_index, pending_count,
                    scr_x, scr_y, scr_w, scr_h, input ready);
    modport sink (input valid, action, entry_index, pending_count,
                  scr_x, scr_y, scr_w, scr_h, output ready);
endinterface

interface drt_cfg_if import drt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/dirty_rectangle_tracker_unit.sv */
// Dirty rectangle tracker: an add passes a scaling stage, then one cell per
// cycle along a chain of TABLE_DEPTH entry cells, then a pending register and
// the output register to res; a flush goes straight to the pending register.
// One item at a time: the next is accepted only once the result moves into the
// output register, later while an earlier result still waits on res.
// Reset clears the pending count and loads the register defaults; entry
// contents stay undefined until written.
module dirty_rectangle_tracker_unit import drt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    drt_cfg_if.sink    cfg,
    drt_req_if.sink    req,
    drt_res_if.source  res
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2((TABLE_DEPTH > 1) ? TABLE_DEPTH : 2);

    logic [SCALE_W-1:0]  x_scale_reg;
    logic [SCALE_W-1:0]  y_scale_reg;
    logic [OFFSET_W-1:0] y_offset_reg;
    logic [SCALE_W-1:0]  width_scale_reg;
    logic [SCALE_W-1:0]  height_scale_reg;

    logic [CNT_W-1:0] entry_count_reg;
    logic             busy_reg;
    logic             pend_valid_reg;
    action_t          pend_action_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [CNT_W-1:0] pend_count_reg;
    rect_t            pend_rect_reg;

    logic             out_valid_reg;
    action_t          out_action_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [CNT_W-1:0] out_count_reg;
    rect_t            out_rect_reg;

    logic req_beat;
    logic add_beat;
    logic flush_beat;
    logic out_load;
    logic sc_valid;
    rect_t sc_rect;

    probe_ctrl_t      chain_ctrl [TABLE_DEPTH+1];
    rect_t            chain_rect [TABLE_DEPTH+1];
    logic [CNT_W-1:0] chain_pos  [TABLE_DEPTH+1];
    logic [IDX_W-1:0] chain_idx  [TABLE_DEPTH+1];

    probe_ctrl_t      tail;
    logic             tail_append;

    assign req_beat = req.valid && req.ready;
    assign add_beat = req_beat && (req.req_type == REQ_ADD);
    assign flush_beat = req_beat && (req.req_type == REQ_FLUSH);
    assign req.ready = !busy_reg;
    assign cfg.ready = 1'b1;
    assign out_load = pend_valid_reg && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg <= SCALE_W'(2);
            y_scale_reg <= SCALE_W'(2);
            y_offset_reg <= '0;
            width_scale_reg <= SCALE_W'(2);
            height_scale_reg <= SCALE_W'(2);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_X_SCALE:  x_scale_reg <= cfg.data[SCALE_W-1:0];
                REG_Y_SCALE:  y_scale_reg <= cfg.data[SCALE_W-1:0];
                REG_Y_OFFSET: y_offset_reg <= cfg.data;
                REG_W_SCALE:  width_scale_reg <= cfg.data[SCALE_W-1:0];
                REG_H_SCALE:  height_scale_reg <= cfg.data[SCALE_W-1:0];
                default:      ;
            endcase
        end
    end

    drt_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (add_beat),
        .x_scale      (x_scale_reg),
        .y_scale      (y_scale_reg),
        .y_offset     (y_offset_reg),
        .width_scale  (width_scale_reg),
        .height_scale (height_scale_reg),
        .pos_x        (req.pos_x),
        .pos_y        (req.pos_y),
        .width_groups (req.width_groups),
        .height_rows  (req.height_rows),
        .valid        (sc_valid),
        .rect         (sc_rect)
    );

    always_comb
    begin
        chain_ctrl[0].valid = sc_valid;
        chain_ctrl[0].done = 1'b0;
        chain_ctrl[0].action = ACT_FULL;
        chain_rect[0] = sc_rect;
        chain_pos[0] = '0;
        chain_idx[0] = '0;
    end

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        drt_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .entry_count (entry_count_reg),
            .ctrl_in     (chain_ctrl[k]),
            .rect_in     (chain_rect[k]),
            .pos_in      (chain_pos[k]),
            .idx_in      (chain_idx[k]),
            .ctrl_out    (chain_ctrl[k+1]),
            .rect_out    (chain_rect[k+1]),
            .pos_out     (chain_pos[k+1]),
            .idx_out     (chain_idx[k+1])
        );
    end

    assign tail = chain_ctrl[TABLE_DEPTH];
    assign tail_append = tail.done && (tail.action == ACT_APPEND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            busy_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_beat)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end

            if (flush_beat)
            begin
                entry_count_reg <= '0;
            end
            else if (tail.valid && tail_append)
            begin
                entry_count_reg <= entry_count_reg + CNT_W'(1);
            end

            if (flush_beat || tail.valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (flush_beat)
        begin
            pend_action_reg <= ACT_FLUSH;
            pend_idx_reg <= '0;
            pend_count_reg <= '0;
            pend_rect_reg <= '0;
        end
        else if (tail.valid)
        begin
            pend_action_reg <= tail.done ? tail.action : ACT_FULL;
            pend_idx_reg <= tail.done ? chain_idx[TABLE_DEPTH] : '0;
            pend_count_reg <= tail_append ? entry_count_reg + CNT_W'(1) : entry_count_reg;
            pend_rect_reg <= chain_rect[TABLE_DEPTH];
        end

        if (out_load)
        begin
            out_action_reg <= pend_action_reg;
            out_idx_reg <= pend_idx_reg;
            out_count_reg <= pend_count_reg;
            out_rect_reg <= pend_rect_reg;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.action = out_action_reg;
    assign res.entry_index = OUT_IDX_W'(out_idx_reg);
    assign res.pending_count = OUT_CNT_W'(out_count_reg);
    assign res.scr_x = out_rect_reg.x;
    assign res.scr_y = out_rect_reg.y;
    assign res.scr_w = out_rect_reg.w;
    assign res.scr_h = out_rect_reg.h;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("pending count above table depth");

    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> busy_reg)
        else $error("pending result while idle");

    a_tail_free: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (busy_reg && !pend_valid_reg))
        else $error("scan finished with result slot occupied");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        flush_beat |=> (entry_count_reg == '0))
        else $error("flush did not empty the table");

endmodule

/* src/drt_scale.sv */
// Scaling stage: virtual rectangle to saturated screen rectangle, registered.
// Depends on drt_pkg.
module drt_scale import drt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SCALE_W-1:0]    x_scale,
    input  logic [SCALE_W-1:0]    y_scale,
    input  logic [OFFSET_W-1:0]   y_offset,
    input  logic [SCALE_W-1:0]    width_scale,
    input  logic [SCALE_W-1:0]    height_scale,
    input  logic [POS_X_W-1:0]    pos_x,
    input  logic [POS_Y_W-1:0]    pos_y,
    input  logic [GROUPS_W-1:0]   width_groups,
    input  logic [ROWS_W-1:0]     height_rows,
    output logic                  valid,
    output rect_t                 rect
);

    logic              valid_reg;
    rect_t             rect_reg;
    rect_t             rect_next;
    logic [EDGE_W-1:0] px;
    logic [EDGE_W-1:0] py;
    logic [EDGE_W-1:0] pw;
    logic [EDGE_W-1:0] ph;

    function automatic logic [COORD_W-1:0] sat(logic [EDGE_W-1:0] v);
        return (v > EDGE_W'(COORD_MAX)) ? COORD_MAX : v[COORD_W-1:0];
    endfunction

    always_comb
    begin
        px = EDGE_W'(pos_x) * EDGE_W'(x_scale);
        py = EDGE_W'(pos_y) * EDGE_W'(y_scale) + EDGE_W'(y_offset);
        pw = (EDGE_W'(width_groups) * EDGE_W'(width_scale)) << 2;
        ph = EDGE_W'(height_rows) * EDGE_W'(height_scale);
        rect_next.x = sat(px);
        rect_next.y = sat(py);
        rect_next.w = sat(pw);
        rect_next.h = sat(ph);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rect_reg <= rect_next;
        end
    end

    assign valid = valid_reg;
    assign rect = rect_reg;

endmodule

/* src/drt_cell.sv */
// One table entry with its compare logic; the probe passes through a
// register to the next cell. Depends on drt_pkg.
module drt_cell import drt_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] entry_count,
    input  probe_ctrl_t      ctrl_in,
    input  rect_t            rect_in,
    input  logic [CNT_W-1:0] pos_in,
    input  logic [IDX_W-1:0] idx_in,
    output probe_ctrl_t      ctrl_out,
    output rect_t            rect_out,
    output logic [CNT_W-1:0] pos_out,
    output logic [IDX_W-1:0] idx_out
);

    rect_t            entry_reg;
    probe_ctrl_t      ctrl_reg;
    probe_ctrl_t      ctrl_next;
    rect_t            rect_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             entry_we;
    logic             active;
    logic             live;

    always_comb
    begin
        active = ctrl_in.valid && !ctrl_in.done;
        live = active && (pos_in < entry_count);
        ctrl_next = ctrl_in;
        idx_next = idx_in;
        entry_we = 1'b0;
        priority if (live && rect_inside(rect_in, entry_reg))
        begin
            ctrl_next.done = 1'b1;
            ctrl_next.action = ACT_DROP;
            idx_next = pos_in[IDX_W-1:0];
        end
        else if (live && rect_inside(entry_reg, rect_in))
        begin
            ctrl_next.done = 1'b1;
            ctrl_next.action = ACT_REPLACE;
            idx_next = pos_in[IDX_W-1:0];
            entry_we = 1'b1;
        end
        else if (active && (pos_in == entry_count))
        begin
            // first free slot: append here
            ctrl_next.done = 1'b1;
            ctrl_next.action = ACT_APPEND;
            idx_next = pos_in[IDX_W-1:0];
            entry_we = 1'b1;
        end
        else
        begin
            ctrl_next = ctrl_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_reg <= rect_in;
        end
        rect_reg <= rect_in;
        pos_reg <= pos_in + CNT_W'(1);
        idx_reg <= idx_next;
    end

    assign ctrl_out = ctrl_reg;
    assign rect_out = rect_reg;
    assign pos_out = pos_reg;
    assign idx_out = idx_reg;

endmodule
